// ===== hw/rtl/hxps_pkg.sv =====
// Shared types, constants and helper functions of the HyperX port selector.
package hxps_pkg;

  // Default sizes of the design.
  localparam int NUM_DIMS_DEF   = 3;
  localparam int PORT_LIMIT_DEF = 256;
  localparam int MAX_VCS_DEF    = 8;

  // Field geometry.
  localparam int COORD_W    = 5;
  localparam int WEIGHT_W   = 3;
  localparam int MAX_WEIGHT = 7;
  localparam int BASE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the configuration registers and the tie-break LFSR.
  localparam logic [14:0] ROUTER_ADDRESS_RST = 15'd0;
  localparam logic [14:0] DIM_WIDTHS_RST     = 15'd17476;
  localparam logic [8:0]  DIM_WEIGHTS_RST    = 9'd73;
  localparam logic [6:0]  CONCENTRATION_RST  = 7'd4;
  localparam logic [3:0]  NUM_VCS_RST        = 4'd2;
  localparam logic [15:0] LFSR_SEED          = 16'hACE1;

  typedef enum logic [2:0] {
    REG_ROUTER_ADDRESS,
    REG_DIM_WIDTHS,
    REG_DIM_WEIGHTS,
    REG_CONCENTRATION,
    REG_NUM_VCS
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] router_address;
    logic [14:0] dim_widths;
    logic [8:0]  dim_weights;
    logic [6:0]  concentration;
    logic [3:0]  num_vcs;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_ARRIVE,
    KIND_ROUTE
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [14:0] dest_coords;
    logic [5:0]  dest_terminal;
    logic [2:0]  input_vc;
    logic [7:0]  update_port;
    logic [2:0]  update_vc;
    logic [7:0]  update_value;
  } item_t;

  // Coordinate of one dimension out of a packed coordinate word.
  function automatic logic [4:0] coord_f(logic [14:0] word, int d);
    return word[COORD_W*d +: COORD_W];
  endfunction

  // VC mask: all VCs below nv, or only those below nv of the given parity.
  function automatic logic [7:0] vc_mask_f(logic [3:0] nv, logic all_vcs, logic parity);
    logic [7:0] m;
    m = '0;
    for (int v = 0; v < 8; v++) begin
      m[v] = (4'(v) < nv) && (all_vcs || (1'(v) == parity));
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/hxps_front.sv =====
// Front end: accepts input transfers and classifies them for the queue.
module hxps_front #(
  parameter int NUM_DIMS = hxps_pkg::NUM_DIMS_DEF
) (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  logic [14:0]     dest_coords_i,
  input  logic [5:0]      dest_terminal_i,
  input  logic [2:0]      input_vc_i,
  input  logic [7:0]      update_port_i,
  input  logic [2:0]      update_vc_i,
  input  logic [7:0]      update_value_i,
  input  logic [14:0]     router_address_i,
  input  logic            clearing_i,
  input  logic            push_ready_i,
  output logic            push_valid_o,
  output hxps_pkg::item_t push_item_o
);
  import hxps_pkg::*;

  logic match;

  // The request has arrived when every used coordinate equals our own.
  always_comb begin
    match = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (coord_f(router_address_i, d) != coord_f(dest_coords_i, d)) begin
        match = 1'b0;
      end
    end
  end

  // Nothing is taken while the table is being cleared or the queue is full.
  assign in_stall_o   = clearing_i || !push_ready_i;
  assign push_valid_o = in_valid_i && !clearing_i;

  // Build the queue entry.
  always_comb begin
    push_item_o.kind          = !mode_i ? KIND_UPDATE : (match ? KIND_ARRIVE : KIND_ROUTE);
    push_item_o.dest_coords   = dest_coords_i;
    push_item_o.dest_terminal = dest_terminal_i;
    push_item_o.input_vc      = input_vc_i;
    push_item_o.update_port   = update_port_i;
    push_item_o.update_vc     = update_vc_i;
    push_item_o.update_value  = update_value_i;
  end

endmodule

// ===== hw/rtl/hxps_queue.sv =====
// Short queue of classified items between the front end and the back end.
module hxps_queue #(
  parameter int DEPTH = hxps_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  hxps_pkg::item_t push_item_i,
  output logic            push_ready_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output hxps_pkg::item_t pop_item_o
);
  import hxps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/hxps_back.sv =====
// Back end: availability table, candidate scoring, tie break and result register.
module hxps_back #(
  parameter int NUM_DIMS   = hxps_pkg::NUM_DIMS_DEF,
  parameter int PORT_LIMIT = hxps_pkg::PORT_LIMIT_DEF,
  parameter int MAX_VCS    = hxps_pkg::MAX_VCS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hxps_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  hxps_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            clearing_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      output_port_o,
  output logic [7:0]      vc_mask_o,
  output logic            arrived_o
);
  import hxps_pkg::*;

  localparam int TBL_DEPTH = PORT_LIMIT * MAX_VCS;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int PW        = $clog2(PORT_LIMIT);
  localparam int VW        = $clog2(MAX_VCS);
  localparam int DW        = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int CAND_MAX  = NUM_DIMS * MAX_WEIGHT;
  localparam int CW        = $clog2(CAND_MAX);
  localparam int TW        = $clog2(CAND_MAX + 1);
  localparam int SW        = $clog2(MAX_VCS * 255 + 1);
  localparam logic [AW-1:0] VCS_A    = AW'(MAX_VCS);
  localparam logic [AW-1:0] CLR_LAST = AW'(TBL_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIM,
    S_LINK,
    S_READ,
    S_SCORE,
    S_FIN,
    S_DIV,
    S_PICK,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_addr_q;
  logic [15:0]         lfsr_q;
  logic [14:0]         dest_q;
  logic [5:0]          term_q;
  logic [2:0]          ivc_q;
  logic [DW-1:0]       d_q;
  logic [BASE_W-1:0]   base_q;
  logic signed [12:0]  dstart_q;
  logic [2:0]          wt_q;
  logic [2:0]          k_q;
  logic [PW-1:0]       cur_port_q;
  logic [VW-1:0]       v_q;
  logic                pend_q;
  logic [SW-1:0]       acc_q;
  logic [TW-1:0]       ncand_q;
  logic [SW-1:0]       best_q;
  logic [TW-1:0]       ties_q;
  logic [TW-1:0]       rem_q;
  logic [3:0]          div_bit_q;
  logic [CW-1:0]       i_q;
  logic [TW-1:0]       cnt_q;
  logic [7:0]          res_port_q;
  logic [7:0]          res_mask_q;
  logic                res_arr_q;
  logic                out_vld_q;
  logic [7:0]          out_port_q;
  logic [7:0]          out_mask_q;
  logic                out_arr_q;

  logic [7:0]          mem_q [TBL_DEPTH];
  logic [7:0]          rdata_q;
  logic [PW-1:0]       cand_q [CAND_MAX];
  logic [SW-1:0]       score_q [CAND_MAX];

  logic [3:0]          nv;
  logic [4:0]          w_raw, w1, src, dst;
  logic [2:0]          wt;
  logic [5:0]          dstp;
  logic signed [7:0]   off;
  logic signed [11:0]  off_wt;
  logic signed [12:0]  dstart_d;
  logic [BASE_W-1:0]   base_d;
  logic signed [12:0]  p;
  logic                p_ok;
  logic                last_link, last_dim;
  logic [AW-1:0]       rd_addr, upd_addr;
  logic                upd_ok;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic [SW-1:0]       score_fin;
  logic [TW:0]         rem_sh, rem_nx;
  logic [15:0]         lfsr_nx;
  logic                out_free;

  // Per-dimension geometry of the current route request.
  always_comb begin
    nv       = (cfg_i.num_vcs > 4'(MAX_VCS)) ? 4'(MAX_VCS) : cfg_i.num_vcs;
    w_raw    = coord_f(cfg_i.dim_widths, int'(d_q));
    w1       = (w_raw == '0) ? 5'd1 : w_raw;
    wt       = cfg_i.dim_weights[WEIGHT_W*d_q +: WEIGHT_W];
    src      = coord_f(cfg_i.router_address, int'(d_q));
    dst      = coord_f(dest_q, int'(d_q));
    dstp     = (dst < src) ? ({1'b0, dst} + {1'b0, w1}) : {1'b0, dst};
    off      = $signed({2'b00, dstp}) - $signed({3'b000, src}) - 8'sd1;
    off_wt   = off * $signed({1'b0, wt});
    dstart_d = $signed({2'b00, base_q}) + 13'(off_wt);
    base_d   = base_q + BASE_W'(w1 - 5'd1) * BASE_W'(wt);
  end

  // Current candidate link port and its range check.
  assign p         = dstart_q + $signed({10'b0, k_q});
  assign p_ok      = !p[12] && (p < $signed(13'(PORT_LIMIT)));
  assign last_link = (k_q == wt_q - 3'd1);
  assign last_dim  = (d_q == DW'(NUM_DIMS - 1));

  // Table addressing.
  assign rd_addr  = AW'(cur_port_q) * VCS_A + AW'(v_q);
  assign upd_ok   = ({1'b0, q_item_i.update_port} < 9'(PORT_LIMIT))
                 && ({1'b0, q_item_i.update_vc} < 4'(MAX_VCS));
  assign upd_addr = AW'(q_item_i.update_port[PW-1:0]) * VCS_A
                  + AW'(q_item_i.update_vc[VW-1:0]);

  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign clearing_o = (state_q == S_CLEAR);

  assign mem_we    = (state_q == S_CLEAR)
                  || (q_pop_o && (q_item_i.kind == KIND_UPDATE) && upd_ok);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : upd_addr;
  assign mem_wdata = (state_q == S_CLEAR) ? 8'd0 : q_item_i.update_value;

  // Score of the candidate, with the last read still in flight.
  assign score_fin = acc_q + (pend_q ? SW'(rdata_q) : '0);

  // One step of the restoring remainder of the LFSR by the tie count.
  assign rem_sh = {rem_q, lfsr_q[div_bit_q]};
  assign rem_nx = (rem_sh >= {1'b0, ties_q}) ? (rem_sh - {1'b0, ties_q}) : rem_sh;

  assign lfsr_nx  = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign out_free = !out_vld_q || !out_stall_i;

  assign out_valid_o   = out_vld_q;
  assign output_port_o = out_port_q;
  assign vc_mask_o     = out_mask_q;
  assign arrived_o     = out_arr_q;

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      lfsr_q     <= LFSR_SEED;
      dest_q     <= '0;
      term_q     <= '0;
      ivc_q      <= '0;
      d_q        <= '0;
      base_q     <= '0;
      dstart_q   <= '0;
      wt_q       <= '0;
      k_q        <= '0;
      cur_port_q <= '0;
      v_q        <= '0;
      pend_q     <= 1'b0;
      acc_q      <= '0;
      ncand_q    <= '0;
      best_q     <= '0;
      ties_q     <= '0;
      rem_q      <= '0;
      div_bit_q  <= '0;
      i_q        <= '0;
      cnt_q      <= '0;
      res_port_q <= '0;
      res_mask_q <= '0;
      res_arr_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      out_port_q <= '0;
      out_mask_q <= '0;
      out_arr_q  <= 1'b0;
    end else begin
      // The output register empties on a transfer unless a new result enters it.
      if (out_vld_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_addr_q == CLR_LAST) begin
            state_q <= S_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            dest_q <= q_item_i.dest_coords;
            term_q <= q_item_i.dest_terminal;
            ivc_q  <= q_item_i.input_vc;
            case (q_item_i.kind)
              KIND_ARRIVE: begin
                res_port_q <= {2'b00, q_item_i.dest_terminal};
                res_mask_q <= vc_mask_f(nv, 1'b1, 1'b0);
                res_arr_q  <= 1'b1;
                state_q    <= S_EMIT;
              end
              KIND_ROUTE: begin
                d_q     <= '0;
                base_q  <= BASE_W'(cfg_i.concentration);
                ncand_q <= '0;
                best_q  <= '0;
                ties_q  <= '0;
                state_q <= S_DIM;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DIM: begin
          dstart_q <= dstart_d;
          wt_q     <= wt;
          base_q   <= base_d;
          k_q      <= '0;
          if ((src != dst) && (wt != '0)) begin
            state_q <= S_LINK;
          end else if (last_dim) begin
            state_q <= S_FIN;
          end else begin
            d_q <= d_q + 1'b1;
          end
        end
        S_LINK: begin
          if (p_ok) begin
            cur_port_q <= p[PW-1:0];
            v_q        <= '0;
            acc_q      <= '0;
            pend_q     <= 1'b0;
            state_q    <= (nv == '0) ? S_SCORE : S_READ;
          end else if (!last_link) begin
            k_q <= k_q + 1'b1;
          end else if (last_dim) begin
            state_q <= S_FIN;
          end else begin
            d_q     <= d_q + 1'b1;
            state_q <= S_DIM;
          end
        end
        S_READ: begin
          pend_q <= 1'b1;
          if (pend_q) begin
            acc_q <= acc_q + SW'(rdata_q);
          end
          if (4'(v_q) == nv - 4'd1) begin
            state_q <= S_SCORE;
          end else begin
            v_q <= v_q + 1'b1;
          end
        end
        S_SCORE: begin
          pend_q  <= 1'b0;
          ncand_q <= ncand_q + 1'b1;
          if (score_fin > best_q) begin
            best_q <= score_fin;
            ties_q <= TW'(1);
          end else if (score_fin == best_q) begin
            ties_q <= ties_q + 1'b1;
          end
          if (!last_link) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_LINK;
          end else if (last_dim) begin
            state_q <= S_FIN;
          end else begin
            d_q     <= d_q + 1'b1;
            state_q <= S_DIM;
          end
        end
        S_FIN: begin
          if (ncand_q == '0) begin
            res_port_q <= '0;
            res_mask_q <= '0;
            res_arr_q  <= 1'b0;
            state_q    <= S_EMIT;
          end else begin
            rem_q     <= '0;
            div_bit_q <= 4'd15;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_nx[TW-1:0];
          if (div_bit_q == '0) begin
            lfsr_q  <= lfsr_nx;
            i_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_PICK;
          end else begin
            div_bit_q <= div_bit_q - 1'b1;
          end
        end
        S_PICK: begin
          i_q <= i_q + 1'b1;
          if (score_q[i_q] == best_q) begin
            if (cnt_q == rem_q) begin
              res_port_q <= 8'(cand_q[i_q]);
              res_mask_q <= vc_mask_f(nv, 1'b0, ~ivc_q[0]);
              res_arr_q  <= 1'b0;
              state_q    <= S_EMIT;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_port_q <= res_port_q;
            out_mask_q <= res_mask_q;
            out_arr_q  <= res_arr_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Availability table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_READ) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Candidate list of the current request.
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCORE) begin
      cand_q[ncand_q[CW-1:0]]  <= cur_port_q;
      score_q[ncand_q[CW-1:0]] <= score_fin;
    end
  end

`ifndef ASSERT_OFF
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (rem_q < ties_q))
    else $error("tie index not below tie count");

  a_ncand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncand_q <= TW'(CAND_MAX))
    else $error("candidate count overflow");

  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("tie-break LFSR locked at zero");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !q_pop_o)
    else $error("queue popped during table clear");

  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && out_free) |=> out_vld_q)
    else $error("result lost at output register");
`endif

endmodule

// ===== hw/rtl/hyperx_adaptive_port_select.sv =====
// Top level of the HyperX adaptive output-port selector.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | mode, coords, terminal, vc, update
//   out     | output    | out_valid_o / out_stall_i | output_port, vc_mask, arrived
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// An update is written into the table as it is popped from the queue. A routed request reads
// the table once per VC of each candidate (at most 21 candidates with 8 VCs), then
// divides the LFSR by the tie count bit by bit and scans the candidates for the chosen
// tie; its speed is set by the single table read port and the tie-break remainder.
// After reset the table is cleared one entry per cycle, all PORT_LIMIT * MAX_VCS entries
// (2048 by default), while in_stall_o is high. A two-entry queue and the output
// register let the input side keep accepting while a result is stalled.
module hyperx_adaptive_port_select #(
  parameter int NUM_DIMS   = hxps_pkg::NUM_DIMS_DEF,
  parameter int PORT_LIMIT = hxps_pkg::PORT_LIMIT_DEF,
  parameter int MAX_VCS    = hxps_pkg::MAX_VCS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [14:0] dest_coords_i,
  input  logic [5:0]  dest_terminal_i,
  input  logic [2:0]  input_vc_i,
  input  logic [7:0]  update_port_i,
  input  logic [2:0]  update_vc_i,
  input  logic [7:0]  update_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  output_port_o,
  output logic [7:0]  vc_mask_o,
  output logic        arrived_o
);
  import hxps_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push_valid, push_ready, pop, pop_valid, clearing;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.router_address <= ROUTER_ADDRESS_RST;
      cfg_q.dim_widths     <= DIM_WIDTHS_RST;
      cfg_q.dim_weights    <= DIM_WEIGHTS_RST;
      cfg_q.concentration  <= CONCENTRATION_RST;
      cfg_q.num_vcs        <= NUM_VCS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROUTER_ADDRESS: cfg_q.router_address <= cfg_wdata_i;
        REG_DIM_WIDTHS:     cfg_q.dim_widths     <= cfg_wdata_i;
        REG_DIM_WEIGHTS:    cfg_q.dim_weights    <= cfg_wdata_i[8:0];
        REG_CONCENTRATION:  cfg_q.concentration  <= cfg_wdata_i[6:0];
        REG_NUM_VCS:        cfg_q.num_vcs        <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Front end: input transfer and classification.
  hxps_front #(
    .NUM_DIMS(NUM_DIMS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .dest_coords_i   (dest_coords_i),
    .dest_terminal_i (dest_terminal_i),
    .input_vc_i      (input_vc_i),
    .update_port_i   (update_port_i),
    .update_vc_i     (update_vc_i),
    .update_value_i  (update_value_i),
    .router_address_i(cfg_q.router_address),
    .clearing_i      (clearing),
    .push_ready_i    (push_ready),
    .push_valid_o    (push_valid),
    .push_item_o     (push_item)
  );

  // Queue between the two halves.
  hxps_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_item_i (push_item),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item)
  );

  // Back end: table, scoring and result.
  hxps_back #(
    .NUM_DIMS  (NUM_DIMS),
    .PORT_LIMIT(PORT_LIMIT),
    .MAX_VCS   (MAX_VCS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (pop_valid),
    .q_item_i     (pop_item),
    .q_pop_o      (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .output_port_o(output_port_o),
    .vc_mask_o    (vc_mask_o),
    .arrived_o    (arrived_o)
  );

endmodule

// ===== tb/hyperx_adaptive_port_select_tb.sv =====
// Self-checking testbench of the HyperX adaptive output-port selector.
module hyperx_adaptive_port_select_tb;

  import hxps_pkg::*;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_ROUTE  = 1'b1;
  localparam int   TABLE_PORTS = 256;
  localparam int   TABLE_VCS   = 8;
  localparam int   CAND_LIMIT  = 21;
  localparam int   SETTLE_CYC  = 800;
  localparam int   HOLD_CYC    = 400;
  localparam int   HOLD_AT     = 60;

  typedef struct {
    logic        mode;
    logic [14:0] dest_coords;
    logic [5:0]  dest_terminal;
    logic [2:0]  input_vc;
    logic [7:0]  update_port;
    logic [2:0]  update_vc;
    logic [7:0]  update_value;
  } req_t;

  typedef struct {
    logic [7:0] output_port;
    logic [7:0] vc_mask;
    logic       arrived;
  } sel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [14:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [14:0] dest_coords_i = '0;
  logic [5:0]  dest_terminal_i = '0;
  logic [2:0]  input_vc_i = '0;
  logic [7:0]  update_port_i = '0;
  logic [2:0]  update_vc_i = '0;
  logic [7:0]  update_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [7:0]  output_port_o;
  logic [7:0]  vc_mask_o;
  logic        arrived_o;

  // Predictor state: its own copy of the table, the LFSR and the registers.
  logic [7:0]  avail_mem [TABLE_PORTS*TABLE_VCS];
  logic [15:0] tie_state;
  logic [14:0] own_addr;
  logic [14:0] widths_reg;
  logic [8:0]  weights_reg;
  logic [6:0]  conc_reg;
  logic [3:0]  vcs_reg;

  req_t pending_reqs[$];
  sel_t expected_sels[$];
  bit   in_xfer = 0;
  int   accepted_cnt = 0;
  int   selections_seen = 0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  int   hold_left = 0;
  bit   hold_done = 0;

  hyperx_adaptive_port_select i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Idling is switched off during one long window of the run.
  function automatic bit idle_now();
    return !(cycle_cnt > 3000 && cycle_cnt < 8000) && ($urandom_range(0, 99) < 36);
  endfunction

  // Computes the selection for one request and advances the predictor state.
  function automatic bit select_port(req_t r, output sel_t s);
    int cand [CAND_LIMIT];
    int unsigned score [CAND_LIMIT];
    int ncand, base, w, wt, src, dst, p, i;
    int unsigned best, ties, pick, nv, sum;
    logic [7:0] mask;
    if (r.mode == MODE_UPDATE) begin
      avail_mem[{r.update_port, r.update_vc}] = r.update_value;
      return 0;
    end
    nv = (vcs_reg > TABLE_VCS) ? TABLE_VCS : vcs_reg;
    if (r.dest_coords == own_addr) begin
      s.output_port = {2'b00, r.dest_terminal};
      s.vc_mask = 8'((1 << nv) - 1);
      s.arrived = 1'b1;
      return 1;
    end
    ncand = 0;
    base = conc_reg;
    for (int d = 0; d < 3; d++) begin
      w = widths_reg[5*d +: 5];
      wt = weights_reg[3*d +: 3];
      src = own_addr[5*d +: 5];
      dst = r.dest_coords[5*d +: 5];
      if (w == 0) w = 1;
      if (src != dst) begin
        if (dst < src) dst += w;
        for (int k = 0; k < wt; k++) begin
          p = base + (dst - src - 1) * wt + k;
          if (p >= 0 && p < TABLE_PORTS && ncand < CAND_LIMIT) begin
            cand[ncand] = p;
            ncand++;
          end
        end
      end
      base += (w - 1) * wt;
    end
    s.arrived = 1'b0;
    if (ncand == 0) begin
      s.output_port = '0;
      s.vc_mask = '0;
      return 1;
    end
    best = 0;
    for (i = 0; i < ncand; i++) begin
      sum = 0;
      for (int v = 0; v < nv; v++) sum += avail_mem[cand[i]*TABLE_VCS + v];
      score[i] = sum;
      if (sum > best) best = sum;
    end
    ties = 0;
    for (i = 0; i < ncand; i++) if (score[i] == best) ties++;
    pick = tie_state % ties;
    tie_state = {tie_state[0] ^ tie_state[2] ^ tie_state[3] ^ tie_state[5],
                 tie_state[15:1]};
    for (i = 0; i < ncand; i++) begin
      if (score[i] == best) begin
        if (pick == 0) break;
        pick--;
      end
    end
    if (i >= ncand) i = ncand - 1;
    mask = '0;
    for (int v = 0; v < nv; v++) if (v[0] == ~r.input_vc[0]) mask[v] = 1'b1;
    s.output_port = 8'(cand[i]);
    s.vc_mask = mask;
    return 1;
  endfunction

  // Driver: offers queued requests, holding the payload while stalled.
  always @(negedge clk_i) begin
    req_t r;
    cycle_cnt <= cycle_cnt + 1;
    if (in_valid_i && !in_xfer) begin
      // Stalled transfer: payload stays as it is.
    end else if (pending_reqs.size() > 0 && !idle_now()) begin
      r = pending_reqs.pop_front();
      in_valid_i <= 1'b1;
      mode_i <= r.mode;
      dest_coords_i <= r.dest_coords;
      dest_terminal_i <= r.dest_terminal;
      input_vc_i <= r.input_vc;
      update_port_i <= r.update_port;
      update_vc_i <= r.update_vc;
      update_value_i <= r.update_value;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Long hold-off of the receiver, counted here in cycles.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && selections_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYC;
      hold_done <= 1;
    end
  end

  // Receiver stall.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= (hold_left > 0) || idle_now();
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin
    req_t r;
    sel_t s, e;
    in_xfer = in_valid_i && !in_stall_o;
    if (in_xfer) begin
      r.mode = mode_i;
      r.dest_coords = dest_coords_i;
      r.dest_terminal = dest_terminal_i;
      r.input_vc = input_vc_i;
      r.update_port = update_port_i;
      r.update_vc = update_vc_i;
      r.update_value = update_value_i;
      accepted_cnt++;
      if (select_port(r, s)) expected_sels.push_back(s);
    end
    if (out_valid_o && !out_stall_i) begin
      selections_seen++;
      if (expected_sels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: port %0d mask %h arrived %0d",
                   output_port_o, vc_mask_o, arrived_o);
      end else begin
        e = expected_sels.pop_front();
        if (e.output_port !== output_port_o || e.vc_mask !== vc_mask_o ||
            e.arrived !== arrived_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected port %0d mask %h arrived %0d, got %0d %h %0d",
                     selections_seen, e.output_port, e.vc_mask, e.arrived,
                     output_port_o, vc_mask_o, arrived_o);
        end
      end
    end
  end

  // One register write; the block is idle, so the predictor copy follows at once.
  task automatic write_reg(reg_idx_e idx, logic [14:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ROUTER_ADDRESS: own_addr = data;
      REG_DIM_WIDTHS:     widths_reg = data;
      REG_DIM_WEIGHTS:    weights_reg = data[8:0];
      REG_CONCENTRATION:  conc_reg = data[6:0];
      REG_NUM_VCS:        vcs_reg = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [14:0] addr, logic [14:0] wid, logic [8:0] wgt,
                            logic [6:0] conc, logic [3:0] nv);
    write_reg(REG_ROUTER_ADDRESS, addr);
    write_reg(REG_DIM_WIDTHS, wid);
    write_reg(REG_DIM_WEIGHTS, 15'(wgt));
    write_reg(REG_CONCENTRATION, 15'(conc));
    write_reg(REG_NUM_VCS, 15'(nv));
  endtask

  task automatic push_req(logic mode, logic [14:0] dest, logic [5:0] term, logic [2:0] ivc,
                          logic [7:0] port, logic [2:0] vc, logic [7:0] value);
    req_t r;
    r.mode = mode;
    r.dest_coords = dest;
    r.dest_terminal = term;
    r.input_vc = ivc;
    r.update_port = port;
    r.update_vc = vc;
    r.update_value = value;
    pending_reqs.push_back(r);
  endtask

  // Random requests: updates aimed near the link ports, routes mostly inside the widths.
  task automatic push_random(int n);
    logic [14:0] dest;
    logic [7:0] port, value;
    int w, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      for (int d = 0; d < 3; d++) begin
        w = widths_reg[5*d +: 5];
        if (w == 0) w = 1;
        dest[5*d +: 5] = ($urandom_range(0, 3) == 0) ? own_addr[5*d +: 5]
                                                     : 5'($urandom_range(0, w - 1));
      end
      if (sel < 10) dest = 15'($urandom);
      else if (sel < 20) dest = own_addr;
      port = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                         : 8'(conc_reg + $urandom_range(0, 60));
      case ($urandom_range(0, 3))
        0: value = 8'd0;
        1: value = 8'd255;
        default: value = 8'($urandom);
      endcase
      push_req(($urandom_range(0, 99) < 55) ? MODE_ROUTE : MODE_UPDATE, dest,
               6'($urandom), 3'($urandom), port, 3'($urandom), value);
    end
  endtask

  // Waits until every request is in and every result is out, then lets the block settle.
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_sels.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin
    own_addr = ROUTER_ADDRESS_RST;
    widths_reg = DIM_WIDTHS_RST;
    weights_reg = DIM_WEIGHTS_RST;
    conc_reg = CONCENTRATION_RST;
    vcs_reg = NUM_VCS_RST;
    tie_state = LFSR_SEED;
    for (int i = 0; i < TABLE_PORTS*TABLE_VCS; i++) avail_mem[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration: table extremes, ties, arrivals.
    push_req(MODE_ROUTE, 15'h0421, 6'd0, 3'd0, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h0000, 6'd63, 3'd7, 8'hFF, 3'd7, 8'hFF);
    push_req(MODE_UPDATE, 15'h7FFF, 6'd63, 3'd7, 8'd255, 3'd7, 8'd255);
    push_req(MODE_UPDATE, 15'h0000, 6'd0, 3'd0, 8'd0, 3'd0, 8'd0);
    push_req(MODE_UPDATE, 15'h0000, 6'd0, 3'd0, 8'd5, 3'd0, 8'd255);
    push_req(MODE_UPDATE, 15'h0000, 6'd0, 3'd0, 8'd5, 3'd1, 8'd255);
    push_req(MODE_ROUTE, 15'h0001, 6'd0, 3'd0, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h0003, 6'd0, 3'd1, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h0C63, 6'd9, 3'd6, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h7FFF, 6'd63, 3'd7, 8'hFF, 3'd7, 8'hFF);
    push_req(MODE_UPDATE, 15'h0000, 6'd0, 3'd0, 8'd12, 3'd0, 8'd1);
    push_req(MODE_ROUTE, 15'h0400, 6'd0, 3'd2, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h0020, 6'd0, 3'd3, 8'd0, 3'd0, 8'd0);
    drain();

    // Largest values: wide dimensions, many links, out-of-range candidates.
    set_config(15'h7FFF, 15'h7FFF, 9'h1FF, 7'd127, 4'd15);
    push_req(MODE_ROUTE, 15'h0000, 6'd63, 3'd0, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h7FFF, 6'd63, 3'd0, 8'd0, 3'd0, 8'd0);
    push_random(50);
    drain();

    // Zero widths and weights: no candidate at all; VC counts of zero and one.
    set_config(15'h0000, 15'h0000, 9'h000, 7'd0, 4'd0);
    push_req(MODE_ROUTE, 15'h0421, 6'd1, 3'd0, 8'd0, 3'd0, 8'd0);
    push_req(MODE_ROUTE, 15'h0000, 6'd2, 3'd0, 8'd0, 3'd0, 8'd0);
    push_random(20);
    drain();
    set_config(15'h0000, 15'h4210, 9'h049, 7'd1, 4'd1);
    push_random(30);
    drain();

    // Typical configurations with random content.
    for (int ph = 0; ph < 6; ph++) begin
      set_config(15'($urandom_range(0, 3) | ($urandom_range(0, 3) << 5)
                     | ($urandom_range(0, 3) << 10)),
                 15'($urandom_range(1, 16) | ($urandom_range(1, 16) << 5)
                     | ($urandom_range(1, 16) << 10)),
                 9'($urandom), 7'($urandom_range(1, 64)), 4'($urandom_range(2, 8)));
      push_random(70);
      drain();
    end

    if (mismatch_cnt == 0 && expected_sels.size() == 0) begin
      $display("hyperx_adaptive_port_select: match");
    end else begin
      $display("hyperx_adaptive_port_select: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("hyperx_adaptive_port_select: mismatch");
    $finish;
  end

endmodule
